// ===== rtl/sorted_priority_queue_top_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Types, codes and sizes shared by the queue cells, top level and checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_TOP    = 2'd2,
        KIND_SEARCH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_LE = 2'd0,
        MODE_LT = 2'd1,
        MODE_GE = 2'd2,
        MODE_GT = 2'd3
    } order_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CMP   = 2'd1,
        ST_APPLY = 2'd2
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD_NEW   = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic     eval;
        cell_op_t op;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } ent_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic signed [31:0] out_priority;
        logic               found;
        status_t            status;
        logic               now_empty;
    } rsp_t;

endpackage

// ===== rtl/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// Row of compare-and-shift cells kept sorted by a selectable priority relation.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  --------+-----+------------------+----------------------------------
//  req     | in  | req_valid/stall  | kind, item_value, item_priority
//  rsp     | out | rsp_valid/stall  | out_value, out_priority, found,
//          |     |                  | status, now_empty
//  cfg     | in  | cfg_valid/ready  | order_mode
//
//  Each request passes through capture, a compare in every cell into its flag
//  registers, then the insert or shift of the row together with the load of
//  the response register.
//  A new request is taken once the previous one has reached the response
//  register; a stalled response holds the apply step.
//  Reset empties the queue and sets order_mode to a<=b.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue_top
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spq_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_data
);

    localparam int D  = spq_pkg::DEPTH;
    localparam int CW = spq_pkg::CNT_W;

    spq_pkg::state_t   state_reg;
    spq_pkg::state_t   state_next;
    spq_pkg::req_t     req_reg;
    spq_pkg::req_t     req_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    spq_pkg::order_t   order_reg;
    spq_pkg::order_t   order_next;
    spq_pkg::rsp_t     rsp_reg;
    spq_pkg::rsp_t     rsp_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;

    logic              req_take;
    logic              apply_fire;
    logic              full;
    logic              empty;
    logic              do_push;
    logic              do_pop;
    logic              eval;
    spq_pkg::ent_t     fresh;
    spq_pkg::ent_t     cell_ent [D];
    logic [D-1:0]      occ;
    logic [D-1:0]      fail_vec;
    logic [D-1:0]      match_vec;
    logic [D-1:0]      fail_neg;
    logic [D-1:0]      first_fail;
    logic [D-1:0]      past_first;
    spq_pkg::cell_ctrl_t cell_ctrl [D];

    assign req_take   = req_valid && !req_stall;
    assign full       = (count_reg == CW'(D));
    assign empty      = (count_reg == '0);
    assign fresh      = '{value: req_reg.item_value, prio: req_reg.item_priority};

    // lowest failing cell is the insert point; cells above it move up
    assign fail_neg   = ~fail_vec + D'(1);
    assign first_fail = fail_vec & fail_neg;
    assign past_first = (fail_vec | fail_neg) & ~first_fail;

    assign do_push = apply_fire && (req_reg.kind == spq_pkg::KIND_PUSH) && !full;
    assign do_pop  = apply_fire && (req_reg.kind == spq_pkg::KIND_POP) && !empty;

    generate
        for (genvar i = 0; i < D; i++)
        begin : g_cell
            assign occ[i] = (count_reg > CW'(i));

            always_comb
            begin
                cell_ctrl[i].eval = eval;
                if (do_push && first_fail[i])
                begin
                    cell_ctrl[i].op = spq_pkg::CELL_LOAD_NEW;
                end
                else if (do_push && past_first[i])
                begin
                    cell_ctrl[i].op = spq_pkg::CELL_FROM_LEFT;
                end
                else if (do_pop)
                begin
                    cell_ctrl[i].op = spq_pkg::CELL_FROM_RIGHT;
                end
                else
                begin
                    cell_ctrl[i].op = spq_pkg::CELL_HOLD;
                end
            end

            spq_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl[i]),
                .order_mode (order_reg),
                .occupied   (occ[i]),
                .fresh      (fresh),
                .left       ((i == 0) ? fresh : cell_ent[(i == 0) ? 0 : i - 1]),
                .right      ((i == D - 1) ? cell_ent[i] : cell_ent[(i == D - 1) ? i : i + 1]),
                .ent        (cell_ent[i]),
                .fail       (fail_vec[i]),
                .match      (match_vec[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        order_next     = order_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        req_stall      = (state_reg != spq_pkg::ST_IDLE);
        cfg_ready      = 1'b1;
        eval           = 1'b0;
        apply_fire     = 1'b0;

        if (cfg_valid)
        begin
            order_next = spq_pkg::order_t'(cfg_data);
        end

        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    req_next   = req;
                    state_next = spq_pkg::ST_CMP;
                end
            end
            spq_pkg::ST_CMP:
            begin
                eval       = 1'b1;
                state_next = spq_pkg::ST_APPLY;
            end
            spq_pkg::ST_APPLY:
            begin
                // hold until the response slot frees up
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    apply_fire     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = spq_pkg::ST_IDLE;
                    rsp_next       = '{out_value: '0, out_priority: '0, found: 1'b0,
                                       status: spq_pkg::STAT_OK, now_empty: empty};
                    case (req_reg.kind)
                        spq_pkg::KIND_PUSH:
                        begin
                            if (full)
                            begin
                                rsp_next.status = spq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                count_next         = count_reg + CW'(1);
                                rsp_next.now_empty = 1'b0;
                            end
                        end
                        spq_pkg::KIND_POP,
                        spq_pkg::KIND_TOP:
                        begin
                            if (empty)
                            begin
                                rsp_next.status = spq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                rsp_next.out_value    = cell_ent[0].value;
                                rsp_next.out_priority = cell_ent[0].prio;
                                if (req_reg.kind == spq_pkg::KIND_POP)
                                begin
                                    count_next         = count_reg - CW'(1);
                                    rsp_next.now_empty = (count_reg == CW'(1));
                                end
                            end
                        end
                        spq_pkg::KIND_SEARCH:
                        begin
                            rsp_next.found = |match_vec;
                        end
                        default:
                        begin
                            rsp_next.status = spq_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::ST_IDLE;
            count_reg     <= '0;
            order_reg     <= spq_pkg::MODE_LE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            order_reg     <= order_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry, compares it against the request and moves data along the row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::order_t    order_mode,
    input  logic               occupied,
    input  spq_pkg::ent_t      fresh,
    input  spq_pkg::ent_t      left,
    input  spq_pkg::ent_t      right,
    output spq_pkg::ent_t      ent,
    output logic               fail,
    output logic               match
);

    spq_pkg::ent_t ent_reg;
    spq_pkg::ent_t ent_next;
    logic          fail_reg;
    logic          fail_next;
    logic          match_reg;
    logic          match_next;
    logic          holds;

    // relation stored-before-new on priorities
    always_comb
    begin
        case (order_mode)
            spq_pkg::MODE_LE: holds = ent_reg.prio <= fresh.prio;
            spq_pkg::MODE_LT: holds = ent_reg.prio <  fresh.prio;
            spq_pkg::MODE_GE: holds = ent_reg.prio >= fresh.prio;
            spq_pkg::MODE_GT: holds = ent_reg.prio >  fresh.prio;
            default:          holds = 1'b0;
        endcase
    end

    always_comb
    begin
        // an empty slot always stops the scan
        fail_next  = ctrl.eval ? (!occupied || !holds) : fail_reg;
        match_next = ctrl.eval ? (occupied && (ent_reg.value == fresh.value)) : match_reg;
        case (ctrl.op)
            spq_pkg::CELL_HOLD:       ent_next = ent_reg;
            spq_pkg::CELL_LOAD_NEW:   ent_next = fresh;
            spq_pkg::CELL_FROM_LEFT:  ent_next = left;
            spq_pkg::CELL_FROM_RIGHT: ent_next = right;
            default:                  ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            fail_reg  <= fail_next;
            match_reg <= match_next;
        end
    end

    assign ent   = ent_reg;
    assign fail  = fail_reg;
    assign match = match_reg;

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue port checker
// Watches the top level ports and flags responses that break the queue rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_top_defines.svh"

module spq_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input spq_pkg::rsp_t rsp
);

    logic rsp_ok;
    logic rsp_empty;
    logic rsp_zero;

    assign rsp_ok    = (rsp.status == spq_pkg::STAT_OK);
    assign rsp_empty = (rsp.status == spq_pkg::STAT_EMPTY);
    assign rsp_zero  = (rsp.out_value == '0) && (rsp.out_priority == '0);

    `SPQ_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed")
    `SPQ_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall, req_stall, "no stall after request")
    `SPQ_ASSERT_IMP(a_found_ok, rsp_valid && rsp.found, rsp_ok && !rsp.now_empty, "bad found")
    `SPQ_ASSERT_IMP(a_empty_rsp, rsp_valid && rsp_empty, rsp.now_empty && rsp_zero, "data on empty")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);

// ===== bench/sorted_priority_queue_top_test.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives push, pop, top and search requests under all four ordering modes
// with random idle cycles and response backpressure. Every response is
// compared with a listed expectation or a behavioral queue model kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;

    import spq_pkg::*;

    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam int                 SETTLE   = 8;
    localparam int                 PHASES   = 8;

    typedef enum int {
        MIX_FILL,
        MIX_EVEN,
        MIX_EMPTY
    } mix_t;

    typedef struct {
        req_t rq;
        bit   known;
        rsp_t want;
    } row_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    req_t       req       = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    rsp_t       rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data  = '0;

    // queue model state
    logic signed [31:0] held_value[$];
    logic signed [31:0] held_prio[$];
    order_t             order_sel = MODE_LE;

    row_t hand_q[$];
    rsp_t due_q[$];
    int   issued  = 0;
    int   retired = 0;
    int   errors  = 0;
    int   stall_run = 0;

    sorted_priority_queue_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("simulation failed");
        $finish;
    end

    // true when a stored entry stays in front of an incoming priority
    function automatic bit stays_ahead(input logic signed [31:0] stored,
                                       input logic signed [31:0] incoming);
        case (order_sel)
            MODE_LE: return stored <= incoming;
            MODE_LT: return stored < incoming;
            MODE_GE: return stored >= incoming;
            default: return stored > incoming;
        endcase
    endfunction

    function automatic rsp_t queue_apply(input req_t rq);
        rsp_t r;
        int   pos;
        r = '0;
        r.status = STAT_OK;
        case (rq.kind)
            KIND_PUSH:
            begin
                if (held_value.size() >= DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < held_value.size() && stays_ahead(held_prio[pos], rq.item_priority))
                        pos++;
                    held_value.insert(pos, rq.item_value);
                    held_prio.insert(pos, rq.item_priority);
                end
            end
            KIND_POP, KIND_TOP:
            begin
                if (held_value.size() == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    r.out_value    = held_value[0];
                    r.out_priority = held_prio[0];
                    if (rq.kind == KIND_POP)
                    begin
                        void'(held_value.pop_front());
                        void'(held_prio.pop_front());
                    end
                end
            end
            default:
            begin
                foreach (held_value[i])
                    if (held_value[i] == rq.item_value)
                        r.found = 1'b1;
            end
        endcase
        r.now_empty = (held_value.size() == 0);
        return r;
    endfunction

    function automatic row_t stim(input kind_t k, input logic signed [31:0] v,
                                  input logic signed [31:0] p);
        row_t r;
        r.rq    = '{kind: k, item_value: v, item_priority: p};
        r.known = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic row_t stim_exp(input kind_t k, input logic signed [31:0] v,
                                      input logic signed [31:0] p,
                                      input logic signed [31:0] ov,
                                      input logic signed [31:0] op,
                                      input logic f, input status_t st,
                                      input logic ne);
        row_t r;
        r       = stim(k, v, p);
        r.known = 1'b1;
        r.want  = '{out_value: ov, out_priority: op, found: f, status: st, now_empty: ne};
        return r;
    endfunction

    function automatic logic signed [31:0] pick_word(input int span);
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return int'($urandom_range(0, span - 1)) - span / 2;
        if (p < 80)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic row_t rand_row(input mix_t mx);
        int    p;
        int    t_push;
        int    t_pop;
        int    t_top;
        kind_t k;
        case (mx)
            MIX_FILL:
            begin
                t_push = 80; t_pop = 88; t_top = 94;
            end
            MIX_EMPTY:
            begin
                t_push = 15; t_pop = 75; t_top = 88;
            end
            default:
            begin
                t_push = 35; t_pop = 65; t_top = 80;
            end
        endcase
        p = $urandom_range(0, 99);
        if (p < t_push)
            k = KIND_PUSH;
        else if (p < t_pop)
            k = KIND_POP;
        else if (p < t_top)
            k = KIND_TOP;
        else
            k = KIND_SEARCH;
        return stim(k, pick_word(16), pick_word(9));
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send(input row_t r);
        hand_q.push_back(r);
        req       <= r.rq;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        issued++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // hold requests until every response is back
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (retired < issued)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_order(input order_t m);
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        order_sel = m;
    endtask

    // response backpressure: free runs, short stalls and a few long ones
    always @(posedge clk)
    begin
        int p;
        if (stall_run > 0)
        begin
            stall_run--;
        end
        else
        begin
            p = $urandom_range(0, 99);
            if (p < 45)
            begin
                rsp_stall <= 1'b0;
                stall_run = $urandom_range(1, 30);
            end
            else if (p < 90)
            begin
                rsp_stall <= 1'b1;
                stall_run = $urandom_range(0, 2);
            end
            else
            begin
                rsp_stall <= 1'b1;
                stall_run = $urandom_range(8, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_t calc;
        rsp_t want;
        row_t note;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                calc = queue_apply(req);
                note = hand_q.pop_front();
                due_q.push_back(note.known ? note.want : calc);
            end
            if (rsp_valid && !rsp_stall)
            begin
                retired++;
                if (due_q.size() == 0)
                begin
                    $error("response with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = due_q.pop_front();
                    if (rsp.out_value !== want.out_value)
                    begin
                        $error("out_value: expected %0d, got %0d", want.out_value, rsp.out_value);
                        errors++;
                    end
                    if (rsp.out_priority !== want.out_priority)
                    begin
                        $error("out_priority: expected %0d, got %0d",
                               want.out_priority, rsp.out_priority);
                        errors++;
                    end
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, rsp.found);
                        errors++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.now_empty !== want.now_empty)
                    begin
                        $error("now_empty: expected %0d, got %0d", want.now_empty, rsp.now_empty);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        row_t   plan [20];
        order_t phase_mode [PHASES];
        mix_t   phase_mix [PHASES];
        int     phase_len [PHASES];
        bit     steady;

        phase_mode = '{MODE_GT, MODE_LT, MODE_GE, MODE_LE, MODE_GT, MODE_LT, MODE_GE, MODE_LE};
        phase_mix  = '{MIX_FILL, MIX_EVEN, MIX_FILL, MIX_EMPTY,
                       MIX_EVEN, MIX_EMPTY, MIX_FILL, MIX_EVEN};
        phase_len  = '{70, 50, 60, 70, 50, 50, 50, 50};

        // reset order is a<=b: equal priorities go behind older entries
        plan = '{
            stim_exp(KIND_POP,    0,        0,        0, 0, 1'b0, STAT_EMPTY, 1'b1),
            stim_exp(KIND_TOP,    0,        WORD_MAX, 0, 0, 1'b0, STAT_EMPTY, 1'b1),
            stim_exp(KIND_SEARCH, 0,        0,        0, 0, 1'b0, STAT_OK,    1'b1),
            stim_exp(KIND_PUSH,   WORD_MAX, WORD_MAX, 0, 0, 1'b0, STAT_OK,    1'b0),
            stim_exp(KIND_PUSH,   WORD_MIN, WORD_MIN, 0, 0, 1'b0, STAT_OK,    1'b0),
            stim(KIND_PUSH, 5, 0),
            stim(KIND_PUSH, 6, 0),
            stim(KIND_PUSH, -1, -1),
            stim_exp(KIND_TOP,    0,        0, WORD_MIN, WORD_MIN, 1'b0, STAT_OK, 1'b0),
            stim_exp(KIND_SEARCH, WORD_MAX, WORD_MIN, 0, 0, 1'b1, STAT_OK, 1'b0),
            stim_exp(KIND_SEARCH, 7,        0,        0, 0, 1'b0, STAT_OK, 1'b0),
            stim(KIND_SEARCH, WORD_MIN, -1),
            stim(KIND_POP, 0, 0),
            stim(KIND_POP, WORD_MAX, WORD_MAX),
            stim(KIND_POP, -1, -1),
            stim(KIND_POP, 0, 0),
            stim(KIND_TOP, WORD_MIN, WORD_MIN),
            stim_exp(KIND_POP,    0,  0, WORD_MAX, WORD_MAX, 1'b0, STAT_OK,    1'b1),
            stim_exp(KIND_POP,    0,  0, 0,        0,        1'b0, STAT_EMPTY, 1'b1),
            stim_exp(KIND_SEARCH, -1, 0, 0,        0,        1'b0, STAT_OK,    1'b1)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (plan[i])
        begin
            send(plan[i]);
            idle_gap(gap_len());
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            set_order(phase_mode[ph]);
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_len[ph]; n++)
            begin
                send(rand_row(phase_mix[ph]));
                if (!steady)
                    idle_gap(gap_len());
            end
        end

        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
